// ===== rtl/prpt_pkg.sv =====
package prpt_pkg;

    localparam logic [1:0] OP_PARK_FLOW    = 2'd0;
    localparam logic [1:0] OP_PARK_DEST    = 2'd1;
    localparam logic [1:0] OP_FLOW_RESOLVE = 2'd2;
    localparam logic [1:0] OP_DEST_RESOLVE = 2'd3;

    localparam logic [1:0] KIND_PARK    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_NOMATCH = 2'd2;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    typedef struct packed {
        logic [1:0]  kind;
        logic        request_sent;
        logic        stored;
        logic [3:0]  slot;
        logic [7:0]  packet_ref;
        logic [6:0]  length;
        logic [31:0] timestamp;
        logic        last;
    } t_result;

endpackage

// ===== rtl/prpt_mem.sv =====
module prpt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while the reader stalls
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/prpt_outreg.sv =====
module prpt_outreg import prpt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_free,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
            if (i_push) begin
                r_res <= i_res;
            end
        end
    end

endmodule

// ===== rtl/prpt_ctrl.sv =====
module prpt_ctrl import prpt_pkg::*; #(
    parameter int SLOTS    = 16,
    parameter int IW       = 4,
    parameter int CW       = 5,
    parameter int KW       = 16,
    parameter int DW       = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_op,
    input  logic [15:0]   i_key,
    input  logic [7:0]    i_packet_ref,
    input  logic [6:0]    i_length,
    input  logic [31:0]   i_timestamp,
    input  logic          i_buffer_granted,
    input  logic          i_awaiting_route,
    output logic          o_mem_we,
    output logic [IW-1:0] o_mem_waddr,
    output logic [DW-1:0] o_mem_wdata,
    output logic          o_mem_re,
    output logic [IW-1:0] o_mem_raddr,
    input  logic [DW-1:0] i_mem_rdata,
    output logic          o_push,
    output t_result       o_res,
    input  logic          i_out_free
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    t_state           r_state;
    logic [SLOTS-1:0] r_valid;
    logic [CW-1:0]    r_idx;
    logic [IW-1:0]    r_cidx;
    logic             r_cv;
    logic [CNT_W-1:0] r_cnt;
    logic             r_flow;
    logic [KW-1:0]    r_key;
    logic             r_held_v;
    t_result          r_held;

    logic             accept;
    logic             is_park;
    logic             flow_in;
    logic             found;
    logic [IW-1:0]    free_idx;
    logic [IW+3:0]    free_ext;
    logic [IW+3:0]    cidx_ext;
    logic             rd_flow;
    logic [KW-1:0]    rd_key;
    logic [7:0]       rd_pkt;
    logic [6:0]       rd_len;
    logic [31:0]      rd_time;
    logic             hit;
    logic             stall;
    logic             take;
    logic [CNT_W-1:0] cnt_next;
    logic             issue_ok;
    logic             store;
    t_result          park_res;
    t_result          rel_res;
    t_result          nomatch_res;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign is_park = (i_op == OP_PARK_FLOW) || (i_op == OP_PARK_DEST);
    assign flow_in = (i_op == OP_PARK_FLOW) || (i_op == OP_FLOW_RESOLVE);

    // lowest free slot
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                found    = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign free_ext = {4'b0, free_idx};
    assign cidx_ext = {4'b0, r_cidx};
    assign store    = i_buffer_granted && found;

    assign o_mem_we    = accept && is_park && store;
    assign o_mem_waddr = free_idx;
    assign o_mem_wdata = {flow_in, i_key[KW-1:0], i_packet_ref, i_length,
                          flow_in ? i_timestamp : 32'd0};

    assign rd_time = i_mem_rdata[31:0];
    assign rd_len  = i_mem_rdata[38:32];
    assign rd_pkt  = i_mem_rdata[46:39];
    assign rd_key  = i_mem_rdata[47+KW-1:47];
    assign rd_flow = i_mem_rdata[DW-1];

    assign hit = r_cv && r_valid[r_cidx] && (rd_flow == r_flow) && (rd_key == r_key)
                 && (r_cnt != CNT_W'(MAX_RESULTS));
    // a match must push the held release out before taking its place
    assign stall    = hit && r_held_v && !i_out_free;
    assign take     = (r_state == S_SCAN) && hit && !stall;
    assign cnt_next = r_cnt + (take ? CNT_W'(1) : CNT_W'(0));
    assign issue_ok = (r_idx != CW'(SLOTS)) && (cnt_next != CNT_W'(MAX_RESULTS));

    assign o_mem_re    = (r_state == S_SCAN) && !stall && issue_ok;
    assign o_mem_raddr = r_idx[IW-1:0];

    always_comb begin
        park_res              = '0;
        park_res.kind         = KIND_PARK;
        park_res.request_sent = !i_awaiting_route;
        park_res.stored       = store;
        park_res.slot         = store ? free_ext[3:0] : 4'd0;
        park_res.last         = 1'b1;

        rel_res            = '0;
        rel_res.kind       = KIND_RELEASE;
        rel_res.slot       = cidx_ext[3:0];
        rel_res.packet_ref = rd_pkt;
        rel_res.length     = rd_len;
        rel_res.timestamp  = rd_time;
        rel_res.last       = 1'b1;

        nomatch_res      = '0;
        nomatch_res.kind = KIND_NOMATCH;
        nomatch_res.last = 1'b1;

        o_push = 1'b0;
        o_res  = r_held;
        case (r_state)
            S_SCAN: begin
                if (take && r_held_v) begin
                    o_push     = 1'b1;
                    o_res.last = 1'b0;
                end
            end
            S_FIN: begin
                o_push = i_out_free;
                if (!r_held_v) begin
                    o_res = nomatch_res;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_idx    <= '0;
            r_cv     <= 1'b0;
            r_cnt    <= '0;
            r_held_v <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (is_park) begin
                            r_held   <= park_res;
                            r_held_v <= 1'b1;
                            if (store) begin
                                r_valid[free_idx] <= 1'b1;
                            end
                            r_state <= S_FIN;
                        end else begin
                            r_flow  <= flow_in;
                            r_key   <= i_key[KW-1:0];
                            r_idx   <= '0;
                            r_cnt   <= '0;
                            r_cv    <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        r_cv   <= o_mem_re;
                        r_cidx <= r_idx[IW-1:0];
                        if (o_mem_re) begin
                            r_idx <= r_idx + CW'(1);
                        end
                        if (take) begin
                            r_valid[r_cidx] <= 1'b0;
                            r_held          <= rel_res;
                            r_held_v        <= 1'b1;
                            r_cnt           <= cnt_next;
                        end
                        if (!r_cv && !issue_ok) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (i_out_free) begin
                        r_held_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_free)
        else $error("result pushed into a busy output register");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> !r_valid[$past(r_cidx)])
        else $error("released slot still valid");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("release count beyond limit");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_cv && !r_held_v))
        else $error("work left over in idle");

endmodule

// ===== rtl/pending_route_packet_table.sv =====
// Park request: the result is held in the controller, then pushed into the output
// register once that is free; the next request is accepted after the push.
// Resolve request: one slot read per cycle from the slot memory while the output
// does not stall; output stalls hold the scan. The next request is accepted only
// after the final result of the resolve has been pushed.
// Reset clears the slot valid flags; slot memory is not cleared.
module pending_route_packet_table import prpt_pkg::*; #(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_key,
    input  logic [7:0]  i_packet_ref,
    input  logic [6:0]  i_length,
    input  logic [31:0] i_timestamp,
    input  logic        i_buffer_granted,
    input  logic        i_awaiting_route,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic        o_request_sent,
    output logic        o_stored,
    output logic [3:0]  o_slot,
    output logic [7:0]  o_out_packet_ref,
    output logic [6:0]  o_out_length,
    output logic [31:0] o_out_timestamp,
    output logic        o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int KW = (KEY_BITS < 16) ? KEY_BITS : 16;
    localparam int DW = 48 + KW;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    logic          push;
    logic          out_free;
    t_result       push_res;
    t_result       out_res;

    prpt_ctrl #(
        .SLOTS    (SLOTS),
        .IW       (IW),
        .CW       (CW),
        .KW       (KW),
        .DW       (DW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_key            (i_key),
        .i_packet_ref     (i_packet_ref),
        .i_length         (i_length),
        .i_timestamp      (i_timestamp),
        .i_buffer_granted (i_buffer_granted),
        .i_awaiting_route (i_awaiting_route),
        .o_mem_we         (mem_we),
        .o_mem_waddr      (mem_waddr),
        .o_mem_wdata      (mem_wdata),
        .o_mem_re         (mem_re),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdata      (mem_rdata),
        .o_push           (push),
        .o_res            (push_res),
        .i_out_free       (out_free)
    );

    prpt_mem #(
        .DEPTH (SLOTS),
        .AW    (IW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    prpt_outreg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .o_free  (out_free),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_request_sent   = out_res.request_sent;
    assign o_stored         = out_res.stored;
    assign o_slot           = out_res.slot;
    assign o_out_packet_ref = out_res.packet_ref;
    assign o_out_length     = out_res.length;
    assign o_out_timestamp  = out_res.timestamp;
    assign o_last           = out_res.last;

endmodule

// ===== verif/tb_top.sv =====
module tb_top import prpt_pkg::*; ();

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 40;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] key;
        logic [7:0]  packet_ref;
        logic [6:0]  length;
        logic [31:0] timestamp;
        logic        granted;
        logic        awaiting;
    } t_route_req;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic [1:0]  i_op             = '0;
    logic [15:0] i_key            = '0;
    logic [7:0]  i_packet_ref     = '0;
    logic [6:0]  i_length         = '0;
    logic [31:0] i_timestamp      = '0;
    logic        i_buffer_granted = 1'b0;
    logic        i_awaiting_route = 1'b0;
    logic        i_ready          = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic        o_request_sent;
    logic        o_stored;
    logic [3:0]  o_slot;
    logic [7:0]  o_out_packet_ref;
    logic [6:0]  o_out_length;
    logic [31:0] o_out_timestamp;
    logic        o_last;

    t_route_req request_q[$];
    t_route_req on_wire;
    t_result    table_answers_q[$];

    // predicted slot table
    bit          tbl_valid[SLOTS];
    bit          tbl_flow[SLOTS];
    logic [15:0] tbl_key[SLOTS];
    logic [7:0]  tbl_ref[SLOTS];
    logic [6:0]  tbl_len[SLOTS];
    logic [31:0] tbl_ts[SLOTS];

    logic [15:0] flow_keys[4];
    logic [15:0] dest_keys[4];

    int send_idle_pct = 22;
    int recv_idle_pct = 79;
    bit hold_arm      = 1'b0;
    bit hold_used     = 1'b0;
    int hold_left     = 0;
    int n_errors      = 0;
    int n_results     = 0;
    int cycle_count   = 0;

    pending_route_packet_table u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_key            (i_key),
        .i_packet_ref     (i_packet_ref),
        .i_length         (i_length),
        .i_timestamp      (i_timestamp),
        .i_buffer_granted (i_buffer_granted),
        .i_awaiting_route (i_awaiting_route),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_request_sent   (o_request_sent),
        .o_stored         (o_stored),
        .o_slot           (o_slot),
        .o_out_packet_ref (o_out_packet_ref),
        .o_out_length     (o_out_length),
        .o_out_timestamp  (o_out_timestamp),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        n_errors++;
    endtask

    // Park into the lowest free slot, or release every matching slot in order.
    task automatic apply_to_table(input t_route_req r);
        t_result res;
        int      hits;
        bit      is_flow;
        hits    = 0;
        is_flow = (r.op == OP_PARK_FLOW || r.op == OP_FLOW_RESOLVE);
        if (r.op == OP_PARK_FLOW || r.op == OP_PARK_DEST) begin
            res              = '0;
            res.kind         = KIND_PARK;
            res.request_sent = !r.awaiting;
            res.last         = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!tbl_valid[i]) begin
                    if (r.granted) begin
                        tbl_valid[i] = 1'b1;
                        tbl_flow[i]  = is_flow;
                        tbl_key[i]   = r.key;
                        tbl_ref[i]   = r.packet_ref;
                        tbl_len[i]   = r.length;
                        tbl_ts[i]    = is_flow ? r.timestamp : 32'd0;
                        res.stored   = 1'b1;
                        res.slot     = 4'(i);
                    end
                    break;
                end
            end
            table_answers_q.push_back(res);
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (hits < MAX_RESULTS && tbl_valid[i] && tbl_flow[i] == is_flow
                        && tbl_key[i] == r.key) begin
                    res            = '0;
                    res.kind       = KIND_RELEASE;
                    res.slot       = 4'(i);
                    res.packet_ref = tbl_ref[i];
                    res.length     = tbl_len[i];
                    res.timestamp  = tbl_ts[i];
                    tbl_valid[i]   = 1'b0;
                    table_answers_q.push_back(res);
                    hits++;
                end
            end
            if (hits == 0) begin
                res      = '0;
                res.kind = KIND_NOMATCH;
                res.last = 1'b1;
                table_answers_q.push_back(res);
            end else begin
                table_answers_q[table_answers_q.size() - 1].last = 1'b1;
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drive_requests
        t_route_req nxt;
        bit         next_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            next_valid = i_valid;
            if (i_valid && o_ready) begin
                apply_to_table(on_wire);
                next_valid = 1'b0;
            end
            if (!next_valid && request_q.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt              = request_q.pop_front();
                on_wire          <= nxt;
                i_op             <= nxt.op;
                i_key            <= nxt.key;
                i_packet_ref     <= nxt.packet_ref;
                i_length         <= nxt.length;
                i_timestamp      <= nxt.timestamp;
                i_buffer_granted <= nxt.granted;
                i_awaiting_route <= nxt.awaiting;
                next_valid       = 1'b1;
            end
            i_valid <= next_valid;
        end
    end

    // long receiver hold-off, armed once
    always @(posedge i_clk) begin
        if (hold_arm && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_results++;
                if (table_answers_q.size() == 0) begin
                    report_error($sformatf("unexpected result kind %0d slot %0d",
                                           o_kind, o_slot));
                end else begin
                    want = table_answers_q.pop_front();
                    if (o_kind !== want.kind)
                        report_error($sformatf("result %0d kind %0h want %0h",
                                               n_results, o_kind, want.kind));
                    if (o_request_sent !== want.request_sent)
                        report_error($sformatf("result %0d request_sent %0h want %0h",
                                               n_results, o_request_sent, want.request_sent));
                    if (o_stored !== want.stored)
                        report_error($sformatf("result %0d stored %0h want %0h",
                                               n_results, o_stored, want.stored));
                    if (o_slot !== want.slot)
                        report_error($sformatf("result %0d slot %0h want %0h",
                                               n_results, o_slot, want.slot));
                    if (o_out_packet_ref !== want.packet_ref)
                        report_error($sformatf("result %0d packet_ref %0h want %0h",
                                               n_results, o_out_packet_ref, want.packet_ref));
                    if (o_out_length !== want.length)
                        report_error($sformatf("result %0d length %0h want %0h",
                                               n_results, o_out_length, want.length));
                    if (o_out_timestamp !== want.timestamp)
                        report_error($sformatf("result %0d timestamp %0h want %0h",
                                               n_results, o_out_timestamp, want.timestamp));
                    if (o_last !== want.last)
                        report_error($sformatf("result %0d last %0h want %0h",
                                               n_results, o_last, want.last));
                end
            end
            i_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic t_route_req make_req(input logic [1:0] op, input logic [15:0] key,
                                            input logic [7:0] pref, input logic [6:0] len,
                                            input logic [31:0] ts, input logic granted,
                                            input logic awaiting);
        t_route_req r;
        r.op         = op;
        r.key        = key;
        r.packet_ref = pref;
        r.length     = len;
        r.timestamp  = ts;
        r.granted    = granted;
        r.awaiting   = awaiting;
        return r;
    endfunction

    // Mostly park/resolve traffic on a few recurring keys, some stray keys.
    task automatic queue_random_requests(input int count);
        t_route_req r;
        int         pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                r.op = OP_PARK_FLOW;
            else if (pick < 55)
                r.op = OP_PARK_DEST;
            else if (pick < 78)
                r.op = OP_FLOW_RESOLVE;
            else
                r.op = OP_DEST_RESOLVE;
            if ($urandom_range(0, 99) < 85)
                r.key = (r.op == OP_PARK_FLOW || r.op == OP_FLOW_RESOLVE) ?
                        flow_keys[$urandom_range(0, 3)] : dest_keys[$urandom_range(0, 3)];
            else
                r.key = 16'($urandom_range(0, 65535));
            r.packet_ref = 8'($urandom_range(0, 255));
            r.length     = 7'($urandom_range(0, 127));
            r.timestamp  = $urandom;
            r.granted    = ($urandom_range(0, 99) < 88);
            r.awaiting   = 1'($urandom_range(0, 1));
            request_q.push_back(r);
        end
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || i_valid || table_answers_q.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        for (int i = 0; i < 4; i++) begin
            flow_keys[i] = 16'($urandom_range(0, 65535));
            dest_keys[i] = 16'($urandom_range(0, 65535));
        end
        // same value under both kinds: kind must separate them
        dest_keys[0] = flow_keys[0];
        flow_keys[1] = 16'hFFFF;
        dest_keys[1] = 16'h0000;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes, buffer refused, destination timestamp dropped
        request_q.push_back(make_req(OP_PARK_FLOW, 16'h0000, 8'h00, 7'h00, 32'h0,
                                     1'b1, 1'b0));
        request_q.push_back(make_req(OP_PARK_DEST, 16'hFFFF, 8'hFF, 7'h7F,
                                     32'hFFFF_FFFF, 1'b1, 1'b1));
        request_q.push_back(make_req(OP_PARK_FLOW, 16'hFFFF, 8'h55, 7'h2A,
                                     32'hAAAA_AAAA, 1'b0, 1'b1));
        request_q.push_back(make_req(OP_PARK_DEST, 16'h0000, 8'hAA, 7'h55,
                                     32'h5555_5555, 1'b1, 1'b0));
        request_q.push_back(make_req(OP_DEST_RESOLVE, 16'hFFFF, 8'h00, 7'h00, 32'h0,
                                     1'b0, 1'b0));
        request_q.push_back(make_req(OP_FLOW_RESOLVE, 16'hFFFF, 8'hFF, 7'h7F,
                                     32'hFFFF_FFFF, 1'b1, 1'b1));
        request_q.push_back(make_req(OP_FLOW_RESOLVE, 16'h0000, 8'h00, 7'h00, 32'h0,
                                     1'b1, 1'b0));
        request_q.push_back(make_req(OP_DEST_RESOLVE, 16'h0000, 8'h00, 7'h00, 32'h0,
                                     1'b0, 1'b1));
        // fill the table, overflow it, then release all sixteen at once
        for (int i = 0; i < SLOTS; i++)
            request_q.push_back(make_req(OP_PARK_FLOW, 16'h1234, 8'(i * 17), 7'(i * 8),
                                         32'h1000_0000 + i, 1'b1, 1'(i)));
        request_q.push_back(make_req(OP_PARK_DEST, 16'h1234, 8'h77, 7'h11, 32'h0,
                                     1'b1, 1'b0));
        request_q.push_back(make_req(OP_DEST_RESOLVE, 16'h1234, 8'h00, 7'h00, 32'h0,
                                     1'b1, 1'b0));
        request_q.push_back(make_req(OP_FLOW_RESOLVE, 16'h1234, 8'h00, 7'h00, 32'h0,
                                     1'b1, 1'b0));
        queue_random_requests(65);
        wait_drained();

        send_idle_pct = 79;
        recv_idle_pct = 22;
        queue_random_requests(64);
        wait_drained();

        // no idling; stall the output early so the table backs up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_arm      = 1'b1;
        queue_random_requests(64);
        wait_drained();

        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
